### hdl/ptr_pkg.sv
`default_nettype none

package ptr_pkg;

  localparam int DEFAULT_NODE_COUNT    = 64;
  localparam int DEFAULT_MAX_NEIGHBORS = 8;

  localparam logic [15:0] RFAC_RESET = 16'd6554;

  localparam logic [1:0] OP_ADD_ROUTE  = 2'd0;
  localparam logic [1:0] OP_ADD_SOURCE = 2'd1;
  localparam logic [1:0] OP_REINFORCE  = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_ROUTE = 2'd2;

  typedef struct packed {
    logic [5:0]  nb;
    logic [15:0] ph;
    logic        link;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic decide;
    logic walk_begin;
    logic issue;
    logic tsel;
    logic result_load;
  } ptr_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic [1:0] op;
    logic       rt_empty;
    logic       src_empty;
    logic       issue_done;
    logic       pipe_empty;
  } ptr_stat_t;

endpackage

`default_nettype wire

### hdl/ptr_ctrl.sv
`default_nettype none

module ptr_ctrl
  import ptr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire ptr_stat_t st,
  output ptr_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_RWALK  = 3'd4;
  localparam logic [2:0] S_SWALK  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.tsel       = (state == S_SWALK);
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (st.op == OP_REINFORCE && !st.rt_empty) begin
          cmd.walk_begin = 1'b1;
          state_next     = S_RWALK;
        end else if (st.op == OP_REINFORCE && !st.src_empty) begin
          cmd.walk_begin = 1'b1;
          state_next     = S_SWALK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RWALK: begin
        if (!st.issue_done) begin
          cmd.issue = 1'b1;
        end else if (st.pipe_empty) begin
          if (!st.src_empty) begin
            cmd.walk_begin = 1'b1;
            state_next     = S_SWALK;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SWALK: begin
        if (!st.issue_done) begin
          cmd.issue = 1'b1;
        end else if (st.pipe_empty) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // The result register must be free before this transaction's result lands.
        if (!out_valid || out_ready) begin
          cmd.result_load = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

### hdl/ptr_datapath.sv
`default_nettype none

module ptr_datapath
  import ptr_pkg::*;
#(
  parameter int NODE_COUNT    = DEFAULT_NODE_COUNT,
  parameter int MAX_NEIGHBORS = DEFAULT_MAX_NEIGHBORS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [15:0] cfg_write_data,
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  dest_addr,
  input  wire logic [5:0]  source_addr,
  input  wire logic [5:0]  neighbor_addr,
  input  wire logic [15:0] pheromone_in,
  input  wire logic        link_up_in,
  input  wire logic        update_source_table,
  input  wire ptr_cmd_t    cmd,
  output ptr_stat_t        st,
  output logic [1:0]       status,
  output logic [15:0]      rewarded_pheromone,
  output logic             neighbor_found
);

  localparam int ROW_W      = $clog2(NODE_COUNT);
  localparam int SLOT_W     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int FILL_W     = $clog2(MAX_NEIGHBORS + 1);
  localparam int ADDR_W     = ROW_W + SLOT_W;
  localparam int SLOT_DEPTH = NODE_COUNT * (2 ** SLOT_W);
  localparam int EXT_W      = ROW_W + 6;
  localparam int CMP_W      = (ROW_W + 1 > 6) ? ROW_W + 1 : 6;

  logic [15:0] rfac;

  logic [1:0]       lat_op;
  logic [5:0]       lat_nb;
  logic [15:0]      lat_ph;
  logic             lat_link;
  logic             lat_upd;
  logic [ROW_W-1:0] dest_row;
  logic [ROW_W-1:0] src_row;
  logic             dest_ok;
  logic             src_ok;

  logic [EXT_W-1:0] dest_ext;
  logic [EXT_W-1:0] src_ext;

  logic [FILL_W-1:0] route_fill_mem [NODE_COUNT];
  logic [FILL_W-1:0] source_fill_mem [NODE_COUNT];
  logic [FILL_W-1:0] route_fill_rd;
  logic [FILL_W-1:0] source_fill_rd;
  logic [ROW_W-1:0]  clr_row;

  slot_t route_mem [SLOT_DEPTH];
  slot_t source_mem [SLOT_DEPTH];
  slot_t route_rd;
  slot_t source_rd;

  logic [FILL_W-1:0] route_count;
  logic [FILL_W-1:0] src_count;
  logic [FILL_W-1:0] walk_count;
  logic [FILL_W-1:0] walk_idx;

  logic add_route_ok;
  logic add_source_ok;
  logic [1:0] res_st;
  logic [1:0] res_st_next;
  logic [15:0] rewarded;
  logic        found;

  logic              s1_v;
  logic [SLOT_W-1:0] s1_slot;
  slot_t             s1_entry;
  logic              s1_hit;
  logic [16:0]       mul_a;
  logic [16:0]       mul_b;
  logic [33:0]       product;

  logic              s2_v;
  logic [SLOT_W-1:0] s2_slot;
  slot_t             s2_entry;
  logic              s2_hit;
  logic [17:0]       s2_prod;
  logic [18:0]       sum;
  logic [15:0]       new_ph;

  logic              route_we;
  logic [ADDR_W-1:0] route_wr_addr;
  slot_t             route_wr_data;
  logic              source_we;
  logic [ADDR_W-1:0] source_wr_addr;
  slot_t             source_wr_data;

  assign dest_ext = EXT_W'(dest_addr);
  assign src_ext  = EXT_W'(source_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      rfac <= RFAC_RESET;
    end else if (cfg_write_en) begin
      rfac <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_op   <= op;
      lat_nb   <= neighbor_addr;
      lat_ph   <= pheromone_in;
      lat_link <= link_up_in;
      lat_upd  <= update_source_table;
      dest_row <= dest_ext[ROW_W-1:0];
      src_row  <= src_ext[ROW_W-1:0];
      dest_ok  <= CMP_W'(dest_addr) < CMP_W'(NODE_COUNT);
      src_ok   <= CMP_W'(source_addr) < CMP_W'(NODE_COUNT);
    end
  end

  // Fill counts live in memories, so reset is followed by a clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clear) begin
      clr_row <= clr_row + ROW_W'(1);
    end
  end

  assign add_route_ok  = dest_ok && (route_fill_rd < FILL_W'(MAX_NEIGHBORS));
  assign add_source_ok = src_ok && (source_fill_rd < FILL_W'(MAX_NEIGHBORS));

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      route_fill_mem[clr_row] <= '0;
    end else if (cmd.decide && lat_op == OP_ADD_ROUTE && add_route_ok) begin
      route_fill_mem[dest_row] <= route_fill_rd + FILL_W'(1);
    end
    route_fill_rd <= route_fill_mem[dest_row];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      source_fill_mem[clr_row] <= '0;
    end else if (cmd.decide && lat_op == OP_ADD_SOURCE && add_source_ok) begin
      source_fill_mem[src_row] <= source_fill_rd + FILL_W'(1);
    end
    source_fill_rd <= source_fill_mem[src_row];
  end

  // The read addresses stay fixed during a walk, so the fill reads hold steady.
  assign route_count = dest_ok ? route_fill_rd : '0;
  assign src_count   = (lat_upd && src_ok) ? source_fill_rd : '0;
  assign walk_count  = cmd.tsel ? src_count : route_count;

  always_comb begin
    case (lat_op)
      OP_ADD_ROUTE:  res_st_next = add_route_ok ? ST_DONE : ST_FULL;
      OP_ADD_SOURCE: res_st_next = add_source_ok ? ST_DONE : ST_FULL;
      OP_REINFORCE:  res_st_next = (route_count == '0) ? ST_NO_ROUTE : ST_DONE;
      default:       res_st_next = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_st <= res_st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx <= '0;
    end else if (cmd.walk_begin) begin
      walk_idx <= '0;
    end else if (cmd.issue) begin
      walk_idx <= walk_idx + FILL_W'(1);
    end
  end

  // Slot pipeline: read, multiply, then add, saturate and write back.
  always_ff @(posedge clk) begin
    route_rd  <= route_mem[{dest_row, walk_idx[SLOT_W-1:0]}];
    source_rd <= source_mem[{src_row, walk_idx[SLOT_W-1:0]}];
  end

  assign s1_entry = cmd.tsel ? source_rd : route_rd;
  assign s1_hit   = (s1_entry.nb == lat_nb);
  assign mul_a    = s1_hit ? {1'b0, rfac} : (17'h10000 - {1'b0, rfac});
  assign mul_b    = s1_hit ? (17'h10000 - {1'b0, s1_entry.ph}) : {1'b0, s1_entry.ph};
  assign product  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_slot  <= walk_idx[SLOT_W-1:0];
    s2_slot  <= s1_slot;
    s2_entry <= s1_entry;
    s2_hit   <= s1_hit;
    s2_prod  <= product[33:16];
  end

  assign sum    = s2_hit ? (19'(s2_entry.ph) + 19'(s2_prod)) : 19'(s2_prod);
  assign new_ph = (sum > 19'd65535) ? 16'hFFFF : sum[15:0];

  always_comb begin
    route_we      = 1'b0;
    route_wr_addr = {dest_row, s2_slot};
    route_wr_data = '{nb: s2_entry.nb, ph: new_ph, link: s2_entry.link};
    if (cmd.decide && lat_op == OP_ADD_ROUTE && add_route_ok) begin
      route_we      = 1'b1;
      route_wr_addr = {dest_row, route_fill_rd[SLOT_W-1:0]};
      route_wr_data = '{nb: lat_nb, ph: lat_ph, link: lat_link};
    end else if (s2_v && !cmd.tsel) begin
      route_we = 1'b1;
    end
  end

  always_comb begin
    source_we      = 1'b0;
    source_wr_addr = {src_row, s2_slot};
    source_wr_data = '{nb: s2_entry.nb, ph: new_ph, link: s2_entry.link};
    if (cmd.decide && lat_op == OP_ADD_SOURCE && add_source_ok) begin
      source_we      = 1'b1;
      source_wr_addr = {src_row, source_fill_rd[SLOT_W-1:0]};
      source_wr_data = '{nb: lat_nb, ph: lat_ph, link: lat_link};
    end else if (s2_v && cmd.tsel) begin
      source_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[route_wr_addr] <= route_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (source_we) begin
      source_mem[source_wr_addr] <= source_wr_data;
    end
  end

  // Only the first matching routing slot is reported.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      found    <= 1'b0;
      rewarded <= '0;
    end else if (s2_v && !cmd.tsel && s2_hit && !found) begin
      found    <= 1'b1;
      rewarded <= new_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      status             <= res_st;
      rewarded_pheromone <= rewarded;
      neighbor_found     <= found;
    end
  end

  assign st.clear_done = (clr_row == ROW_W'(NODE_COUNT - 1));
  assign st.op         = lat_op;
  assign st.rt_empty   = (route_count == '0);
  assign st.src_empty  = (src_count == '0);
  assign st.issue_done = (walk_idx == walk_count);
  assign st.pipe_empty = !s1_v && !s2_v;

endmodule

`default_nettype wire

### hdl/pheromone_table_reinforce.sv
// Flow: an add or an unused op code latches, reads the row fill, decides and loads
// its result; a reinforce also walks the slots of the routing and source rows (a row
// that is skipped is not walked) through the three-stage read/multiply/write slot
// pipeline around the one shared multiplier, draining it after each row.
// Transactions go one at a time: the next is taken only after the result is registered.
// Reset: a clearing pass over every row zeroes the row fill counts, in_ready low.
`default_nettype none

module pheromone_table_reinforce
  import ptr_pkg::*;
#(
  parameter int NODE_COUNT    = DEFAULT_NODE_COUNT,
  parameter int MAX_NEIGHBORS = DEFAULT_MAX_NEIGHBORS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [15:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  dest_addr,
  input  wire logic [5:0]  source_addr,
  input  wire logic [5:0]  neighbor_addr,
  input  wire logic [15:0] pheromone_in,
  input  wire logic        link_up_in,
  input  wire logic        update_source_table,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      rewarded_pheromone,
  output logic             neighbor_found
);

  ptr_cmd_t  cmd;
  ptr_stat_t st;

  ptr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ptr_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write_en        (cfg_write_en),
    .cfg_write_data      (cfg_write_data),
    .op                  (op),
    .dest_addr           (dest_addr),
    .source_addr         (source_addr),
    .neighbor_addr       (neighbor_addr),
    .pheromone_in        (pheromone_in),
    .link_up_in          (link_up_in),
    .update_source_table (update_source_table),
    .cmd                 (cmd),
    .st                  (st),
    .status              (status),
    .rewarded_pheromone  (rewarded_pheromone),
    .neighbor_found      (neighbor_found)
  );

`ifndef NO_ASSERTIONS
  // One transaction at a time: input is closed right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!out_valid || out_ready))
    else $error("result register loaded while occupied");

  // The walk never issues past the end of the row.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !st.issue_done)
    else $error("slot read issued beyond the row fill");
`endif

endmodule

`default_nettype wire

### test/pheromone_table_reinforce_tb.sv
`default_nettype none

module pheromone_table_reinforce_tb;
  import ptr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES  = DEFAULT_NODE_COUNT;
  localparam int MAX_NB = DEFAULT_MAX_NEIGHBORS;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 190;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  dest;
    logic [5:0]  src;
    logic [5:0]  nb;
    logic [15:0] ph;
    logic        link;
    logic        upd;
  } route_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] rewarded;
    logic        found;
  } route_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = '0;
  logic [5:0]  dest_addr = '0;
  logic [5:0]  source_addr = '0;
  logic [5:0]  neighbor_addr = '0;
  logic [15:0] pheromone_in = '0;
  logic        link_up_in = 1'b0;
  logic        update_source_table = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] rewarded_pheromone;
  logic        neighbor_found;

  pheromone_table_reinforce u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write_en        (cfg_write_en),
    .cfg_write_data      (cfg_write_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .op                  (op),
    .dest_addr           (dest_addr),
    .source_addr         (source_addr),
    .neighbor_addr       (neighbor_addr),
    .pheromone_in        (pheromone_in),
    .link_up_in          (link_up_in),
    .update_source_table (update_source_table),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .rewarded_pheromone  (rewarded_pheromone),
    .neighbor_found      (neighbor_found)
  );

  always #4 clk = ~clk;

  // Shadow copy of both pheromone tables and the reinforcement factor.
  slot_t       route_row  [NODES][MAX_NB];
  logic [3:0]  route_fill [NODES];
  slot_t       source_row [NODES][MAX_NB];
  logic [3:0]  source_fill[NODES];
  logic [15:0] model_factor = RFAC_RESET;

  route_resp_t pending_resp_q[$];
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned sent_count = 0;
  int unsigned hit_count = 0;
  int unsigned full_count = 0;
  int unsigned absent_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] next_pheromone(logic [15:0] p, bit hit);
    longint unsigned pl;
    longint unsigned rl;
    longint unsigned v;
    pl = 64'(p);
    rl = 64'(model_factor);
    if (hit) begin
      v = pl + ((rl * (65536 - pl)) >> 16);
    end else begin
      v = ((65536 - rl) * pl) >> 16;
    end
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Updates the shadow tables for one accepted transaction and returns its response.
  function automatic route_resp_t apply_request(route_req_t q);
    route_resp_t resp;
    int unsigned n;
    bit hit;
    resp.status = ST_DONE;
    resp.rewarded = '0;
    resp.found = 1'b0;
    case (q.op)
      OP_ADD_ROUTE: begin
        n = 32'(route_fill[q.dest]);
        if (n >= MAX_NB) begin
          resp.status = ST_FULL;
          full_count++;
        end else begin
          route_row[q.dest][n].nb = q.nb;
          route_row[q.dest][n].ph = q.ph;
          route_row[q.dest][n].link = q.link;
          route_fill[q.dest] = 4'(n + 1);
        end
      end
      OP_ADD_SOURCE: begin
        n = 32'(source_fill[q.src]);
        if (n >= MAX_NB) begin
          resp.status = ST_FULL;
          full_count++;
        end else begin
          source_row[q.src][n].nb = q.nb;
          source_row[q.src][n].ph = q.ph;
          source_row[q.src][n].link = q.link;
          source_fill[q.src] = 4'(n + 1);
        end
      end
      OP_REINFORCE: begin
        n = 32'(route_fill[q.dest]);
        if (n == 0) begin
          resp.status = ST_NO_ROUTE;
          absent_count++;
        end
        for (int i = 0; i < n; i++) begin
          hit = (route_row[q.dest][i].nb == q.nb);
          route_row[q.dest][i].ph = next_pheromone(route_row[q.dest][i].ph, hit);
          if (hit && !resp.found) begin
            resp.found = 1'b1;
            resp.rewarded = route_row[q.dest][i].ph;
            hit_count++;
          end
        end
        // An empty source row is simply skipped.
        if (q.upd) begin
          n = 32'(source_fill[q.src]);
          for (int i = 0; i < n; i++) begin
            hit = (source_row[q.src][i].nb == q.nb);
            source_row[q.src][i].ph = next_pheromone(source_row[q.src][i].ph, hit);
          end
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  function automatic route_req_t make_request(logic [1:0] o, logic [5:0] d, logic [5:0] s,
                                              logic [5:0] nb, logic [15:0] ph,
                                              logic link, logic upd);
    route_req_t q;
    q.op = o;
    q.dest = d;
    q.src = s;
    q.nb = nb;
    q.ph = ph;
    q.link = link;
    q.upd = upd;
    return q;
  endfunction

  function automatic logic [5:0] pick_row();
    if ($urandom_range(0, 9) < 7) return 6'($urandom_range(0, 15));
    return 6'($urandom_range(0, NODES - 1));
  endfunction

  // Half are reinforcements, mostly naming a neighbor already in the row, so rewards
  // and duplicate hits are common; the rest are adds and the odd unused op.
  function automatic route_req_t random_request();
    route_req_t q;
    int unsigned roll;
    int unsigned n;
    q.dest = pick_row();
    q.src = pick_row();
    q.link = 1'($urandom_range(0, 1));
    q.upd = ($urandom_range(0, 9) < 7);
    roll = $urandom_range(0, 99);
    if (roll < 25) q.op = OP_ADD_ROUTE;
    else if (roll < 45) q.op = OP_ADD_SOURCE;
    else if (roll < 95) q.op = OP_REINFORCE;
    else q.op = OP_UNUSED;
    roll = $urandom_range(0, 99);
    if (roll < 15) q.ph = 16'h0000;
    else if (roll < 30) q.ph = 16'hFFFF;
    else q.ph = 16'($urandom_range(0, 65535));
    n = 32'(route_fill[q.dest]);
    if (q.op == OP_REINFORCE && n > 0 && $urandom_range(0, 3) != 0) begin
      q.nb = route_row[q.dest][$urandom_range(0, n - 1)].nb;
    end else if ($urandom_range(0, 1) == 1) begin
      q.nb = 6'($urandom_range(0, 7));
    end else begin
      q.nb = 6'($urandom_range(0, 63));
    end
    return q;
  endfunction

  task automatic send_request(route_req_t q);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    op <= q.op;
    dest_addr <= q.dest;
    source_addr <= q.src;
    neighbor_addr <= q.nb;
    pheromone_in <= q.ph;
    link_up_in <= q.link;
    update_source_table <= q.upd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_resp_q.insert(pending_resp_q.size(), apply_request(q));
    sent_count++;
  endtask

  // Lowers valid and waits until every expected response has come back.
  task automatic drain_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    error_count++;
    if (error_count <= 50) begin
      $display("MISMATCH result %0d %s: got %0d, expected %0d",
               result_count, field, got, want);
    end
  endtask

  task automatic test_unused_op();
    send_request(make_request(OP_UNUSED, 6'd63, 6'd63, 6'd63, 16'hFFFF, 1'b1, 1'b1));
  endtask

  task automatic test_absent_rows();
    send_request(make_request(OP_REINFORCE, 6'd40, 6'd41, 6'd5, 16'h0000, 1'b0, 1'b1));
  endtask

  // Fills one routing row past capacity, with a duplicate neighbor and full-scale
  // pheromone values, and puts a few slots into matching source rows.
  task automatic test_row_overflow();
    logic [5:0] nbs [9];
    nbs = '{6'd5, 6'd0, 6'd5, 6'd63, 6'd12, 6'd33, 6'd7, 6'd21, 6'd44};
    for (int i = 0; i < 9; i++) begin
      send_request(make_request(OP_ADD_ROUTE, 6'd40, 6'd0, nbs[i],
                                (i % 2 == 0) ? 16'hFFFF : 16'h0000 + 16'(i * 7000),
                                i[0], 1'b0));
    end
    send_request(make_request(OP_ADD_SOURCE, 6'd0, 6'd41, 6'd5, 16'h0000, 1'b1, 1'b0));
    send_request(make_request(OP_ADD_SOURCE, 6'd0, 6'd41, 6'd9, 16'hFFFF, 1'b0, 1'b1));
    send_request(make_request(OP_ADD_SOURCE, 6'd0, 6'd41, 6'd5, 16'h8000, 1'b1, 1'b0));
    send_request(make_request(OP_ADD_SOURCE, 6'd63, 6'd63, 6'd63, 16'hFFFF, 1'b1, 1'b1));
    send_request(make_request(OP_ADD_ROUTE, 6'd63, 6'd63, 6'd63, 16'hFFFF, 1'b1, 1'b1));
  endtask

  task automatic test_reinforce_directed();
    send_request(make_request(OP_REINFORCE, 6'd40, 6'd41, 6'd5, 16'h1234, 1'b1, 1'b1));
    send_request(make_request(OP_REINFORCE, 6'd40, 6'd41, 6'd62, 16'h0000, 1'b0, 1'b0));
    send_request(make_request(OP_REINFORCE, 6'd63, 6'd63, 6'd63, 16'hFFFF, 1'b1, 1'b1));
    send_request(make_request(OP_REINFORCE, 6'd40, 6'd0, 6'd63, 16'h0000, 1'b0, 1'b1));
  endtask

  // Random traffic in phases, each with its own reinforcement factor; one
  // phase runs with neither side idling.
  task automatic test_random_phases();
    logic [15:0] factors [6];
    factors = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, RFAC_RESET};
    factors[4] = 16'($urandom_range(0, 65535));
    foreach (factors[ph]) begin
      drain_responses();
      @(negedge clk);
      cfg_write_en <= 1'b1;
      cfg_write_data <= factors[ph];
      model_factor = factors[ph];
      @(negedge clk);
      cfg_write_en <= 1'b0;
      steady = (ph == 3);
      repeat (ITEMS_PER_PHASE) send_request(random_request());
      steady = 1'b0;
    end
  endtask

  initial begin
    foreach (route_fill[i]) begin
      route_fill[i] = '0;
      source_fill[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unused_op();
    test_absent_rows();
    test_row_overflow();
    test_reinforce_directed();
    test_random_phases();
    drain_responses();
    repeat (30) @(posedge clk);
    $display("Covered %0d transactions, %0d responses: %0d rewarded hits, %0d full-row drops,",
             sent_count, result_count, hit_count, full_count);
    $display("%0d absent routing rows, over six reinforcement factor settings.", absent_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side back-pressure: runs of ready with random stalls between them.
  always @(negedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    route_resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_resp_q.size() == 0) begin
        report_mismatch("unexpected response, status", 32'(status), 0);
      end else begin
        want = pending_resp_q.pop_front();
        if (status !== want.status) begin
          report_mismatch("status", 32'(status), 32'(want.status));
        end
        if (rewarded_pheromone !== want.rewarded) begin
          report_mismatch("rewarded_pheromone", 32'(rewarded_pheromone),
                          32'(want.rewarded));
        end
        if (neighbor_found !== want.found) begin
          report_mismatch("neighbor_found", 32'(neighbor_found), 32'(want.found));
        end
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, pending_resp_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

`default_nettype wire

### sim.f
hdl/ptr_pkg.sv
hdl/ptr_ctrl.sv
hdl/ptr_datapath.sv
hdl/pheromone_table_reinforce.sv
test/pheromone_table_reinforce_tb.sv
